// ----- sv/mfp_interrupt_priority_controller_core_macros.svh -----
// assertion macros shared by the interrupt controller rtl
`ifndef MFP_INTERRUPT_PRIORITY_CONTROLLER_CORE_MACROS_SVH
`define MFP_INTERRUPT_PRIORITY_CONTROLLER_CORE_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication, reset masked
`define MFP_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, reset masked
`define MFP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`else

`define MFP_ASSERT_SAME(label, clk, rst, ante, cons, msg)
`define MFP_ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

// ----- sv/mfp_pkg.sv -----
// types, codes and helpers of the mfp interrupt priority controller
package mfp_pkg;

   // operation codes
   localparam logic [2:0] OP_WRITE  = 3'd0;
   localparam logic [2:0] OP_READ   = 3'd1;
   localparam logic [2:0] OP_ACK    = 3'd2;
   localparam logic [2:0] OP_TICK   = 3'd3;
   localparam logic [2:0] OP_HBLANK = 3'd4;
   localparam logic [2:0] OP_VBLANK = 3'd5;
   localparam logic [2:0] OP_LINES  = 3'd6;

   // register indexes
   localparam logic [3:0] REG_ENA   = 4'd0;
   localparam logic [3:0] REG_ENB   = 4'd1;
   localparam logic [3:0] REG_PNDA  = 4'd2;
   localparam logic [3:0] REG_PNDB  = 4'd3;
   localparam logic [3:0] REG_SVCA  = 4'd4;
   localparam logic [3:0] REG_SVCB  = 4'd5;
   localparam logic [3:0] REG_MSKA  = 4'd6;
   localparam logic [3:0] REG_MSKB  = 4'd7;
   localparam logic [3:0] REG_VEC   = 4'd8;
   localparam logic [3:0] REG_LINES = 4'd9;

   // configuration register indexes
   localparam logic CSR_HBLANK_VECTOR = 1'b0;
   localparam logic CSR_VBLANK_VECTOR = 1'b1;

   // interrupt levels
   localparam logic [2:0] LEVEL_NONE   = 3'd0;
   localparam logic [2:0] LEVEL_HBLANK = 3'd2;
   localparam logic [2:0] LEVEL_VBLANK = 3'd4;
   localparam logic [2:0] LEVEL_MFP    = 3'd6;

   // reset values
   localparam logic [7:0] HBLANK_VECTOR_RST = 8'd26;
   localparam logic [7:0] VBLANK_VECTOR_RST = 8'd28;
   localparam logic [7:0] LINES_RST         = 8'hB9;

   // event channel bits in the b byte
   localparam logic [15:0] TICK_BIT  = 16'h0020;
   localparam logic [15:0] DISK_BIT  = 16'h0080;
   localparam logic [15:0] KBD_BIT   = 16'h0040;
   localparam int          LINE_DISK = 5;
   localparam int          LINE_KBD  = 4;
   localparam int          VEC_SEI   = 3;

   // state that the priority evaluation looks at
   typedef struct packed {
      logic [15:0] enable;
      logic [15:0] pending;
      logic [15:0] service;
      logic [15:0] mask;
      logic [7:0]  lines;
      logic        hblank;
      logic        vblank;
   } mfp_state_type;

   // outcome of the priority evaluation
   typedef struct packed {
      logic [15:0] pending;
      logic [2:0]  level;
      logic [3:0]  winner;
   } mfp_eval_type;

   // highest set bit among channels 15..1, zero when none
   function automatic logic [3:0] top_channel(input logic [15:0] v);
      logic [3:0] res;
      res = 4'd0;
      for (int i = 1; i < 16; i++) begin
         if (v[i]) begin
            res = 4'(i);
         end
      end
      return res;
   endfunction

endpackage

// ----- sv/mfp_eval.sv -----
// priority evaluation: line-driven pends, level and winning channel
module mfp_eval (
   input  mfp_pkg::mfp_state_type st,
   output mfp_pkg::mfp_eval_type  ev
);

   logic [15:0] pend_bits;
   logic [15:0] keep;
   logic [15:0] pnd;
   logic [3:0]  req;
   logic [3:0]  svc;

   // low lines pend the disk and keyboard channels; only then do unenabled b bits drop
   always_comb begin
      pend_bits = 16'h0000;
      if (!st.lines[mfp_pkg::LINE_DISK]) begin
         pend_bits = pend_bits | mfp_pkg::DISK_BIT;
      end
      if (!st.lines[mfp_pkg::LINE_KBD]) begin
         pend_bits = pend_bits | mfp_pkg::KBD_BIT;
      end
      keep = {8'hFF, st.enable[7:0]};
      if (pend_bits != 16'h0000) begin
         pnd = (st.pending | pend_bits) & keep;
      end else begin
         pnd = st.pending;
      end
   end

   // compare highest masked request with highest in-service channel
   always_comb begin
      req = mfp_pkg::top_channel(st.mask & pnd);
      svc = mfp_pkg::top_channel(st.service);
      ev.pending = pnd;
      if (req > svc) begin
         ev.level  = mfp_pkg::LEVEL_MFP;
         ev.winner = req;
      end else begin
         ev.winner = 4'd0;
         if (st.vblank) begin
            ev.level = mfp_pkg::LEVEL_VBLANK;
         end else if (st.hblank) begin
            ev.level = mfp_pkg::LEVEL_HBLANK;
         end else begin
            ev.level = mfp_pkg::LEVEL_NONE;
         end
      end
   end

endmodule

// ----- sv/mfp_interrupt_priority_controller_core.sv -----
// top level of the mfp interrupt priority controller
// Sixteen-channel interrupt priority controller with hblank and vblank autovector
// sources. Each transaction (register write or read, acknowledge, timer tick,
// blank event or line update) is captured in an input register, processed by
// combinational logic that updates the controller state and evaluates the priority,
// and its result is held in an output register. One transaction is accepted every
// cycle while no response is stalled; a result is offered on the response channel
// after the input and output registers, later only while a response is stalled.
// The rate is set by the single evaluate stage between them. The two configuration
// registers hold the vectors returned on level 2 and level 4 acknowledges; the user
// must write them only while the block is idle, which the block does not enforce.
`include "mfp_interrupt_priority_controller_core_macros.svh"
module mfp_interrupt_priority_controller_core (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [2:0] req_operation,
   input  logic [3:0] req_reg_index,
   input  logic [7:0] req_write_data,
   input  logic [2:0] req_ack_level,
   input  logic [7:0] req_line_levels,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_read_data,
   output logic [2:0] rsp_int_level,
   output logic [7:0] rsp_vector,
   input  logic       csr_write_enable,
   input  logic       csr_index,
   input  logic [7:0] csr_write_data
);

   // configuration
   logic [7:0]  hblank_vec_ff;
   logic [7:0]  vblank_vec_ff;

   // input register
   logic        in_valid_ff;
   logic [2:0]  in_op_ff;
   logic [3:0]  in_idx_ff;
   logic [7:0]  in_data_ff;
   logic [2:0]  in_lvl_ff;
   logic [7:0]  in_lines_ff;

   // controller state
   logic [15:0] en_ff, en_in;
   logic [15:0] pnd_ff, pnd_in;
   logic [15:0] svc_ff, svc_in;
   logic [15:0] msk_ff, msk_in;
   logic [7:0]  vec_reg_ff, vec_reg_in;
   logic [7:0]  lines_ff, lines_in;
   logic        hflag_ff, hflag_in;
   logic        vflag_ff, vflag_in;
   logic [2:0]  level_ff;
   logic [3:0]  winner_ff;

   // output register
   logic        rsp_valid_ff;
   logic [7:0]  rd_ff, rd_in;
   logic [7:0]  vec_out_ff, vec_out_in;

   logic                  advance;
   logic [15:0]           ack_bit;
   mfp_pkg::mfp_state_type mid_state;
   mfp_pkg::mfp_eval_type  ev;

   // handshake
   assign advance   = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;

   // effect of the transaction on the state, before evaluation
   always_comb begin
      en_in      = en_ff;
      pnd_in     = pnd_ff;
      svc_in     = svc_ff;
      msk_in     = msk_ff;
      vec_reg_in = vec_reg_ff;
      lines_in   = lines_ff;
      hflag_in   = hflag_ff;
      vflag_in   = vflag_ff;
      rd_in      = 8'd0;
      vec_out_in = 8'd0;
      ack_bit    = 16'd1 << winner_ff;
      case (in_op_ff)
         mfp_pkg::OP_WRITE: begin
            case (in_idx_ff)
               mfp_pkg::REG_ENA: begin
                  en_in[15:8]  = in_data_ff;
                  pnd_in[15:8] = pnd_ff[15:8] & in_data_ff;
               end
               mfp_pkg::REG_ENB: begin
                  en_in[7:0]  = in_data_ff;
                  pnd_in[7:0] = pnd_ff[7:0] & in_data_ff;
               end
               mfp_pkg::REG_PNDA: pnd_in[15:8] = pnd_ff[15:8] & in_data_ff;
               mfp_pkg::REG_PNDB: pnd_in[7:0]  = pnd_ff[7:0] & in_data_ff;
               mfp_pkg::REG_SVCA: svc_in[15:8] = svc_ff[15:8] & in_data_ff;
               mfp_pkg::REG_SVCB: svc_in[7:0]  = svc_ff[7:0] & in_data_ff;
               mfp_pkg::REG_MSKA: msk_in[15:8] = in_data_ff;
               mfp_pkg::REG_MSKB: msk_in[7:0]  = in_data_ff;
               mfp_pkg::REG_VEC:  vec_reg_in   = in_data_ff;
               default: ;
            endcase
         end
         mfp_pkg::OP_READ: begin
            case (in_idx_ff)
               mfp_pkg::REG_ENA:   rd_in = en_ff[15:8];
               mfp_pkg::REG_ENB:   rd_in = en_ff[7:0];
               mfp_pkg::REG_PNDA:  rd_in = pnd_ff[15:8];
               mfp_pkg::REG_PNDB:  rd_in = pnd_ff[7:0];
               mfp_pkg::REG_SVCA:  rd_in = svc_ff[15:8];
               mfp_pkg::REG_SVCB:  rd_in = svc_ff[7:0];
               mfp_pkg::REG_MSKA:  rd_in = msk_ff[15:8];
               mfp_pkg::REG_MSKB:  rd_in = msk_ff[7:0];
               mfp_pkg::REG_VEC:   rd_in = vec_reg_ff;
               mfp_pkg::REG_LINES: rd_in = lines_ff;
               default:            rd_in = 8'hFF;
            endcase
         end
         mfp_pkg::OP_ACK: begin
            case (in_lvl_ff)
               mfp_pkg::LEVEL_MFP: begin
                  if (vec_reg_ff[mfp_pkg::VEC_SEI]) begin
                     svc_in = svc_ff | ack_bit;
                  end
                  pnd_in     = pnd_ff & ~ack_bit;
                  vec_out_in = {vec_reg_ff[7:4], winner_ff};
               end
               mfp_pkg::LEVEL_VBLANK: begin
                  vflag_in   = 1'b0;
                  vec_out_in = vblank_vec_ff;
               end
               mfp_pkg::LEVEL_HBLANK: begin
                  hflag_in   = 1'b0;
                  vec_out_in = hblank_vec_ff;
               end
               default: ;
            endcase
         end
         mfp_pkg::OP_TICK: begin
            pnd_in = (pnd_ff | mfp_pkg::TICK_BIT) & {8'hFF, en_ff[7:0]};
         end
         mfp_pkg::OP_HBLANK: hflag_in = 1'b1;
         mfp_pkg::OP_VBLANK: vflag_in = 1'b1;
         mfp_pkg::OP_LINES:  lines_in = in_lines_ff;
         default: ;
      endcase
   end

   // state seen by the priority evaluation
   always_comb begin
      mid_state.enable  = en_in;
      mid_state.pending = pnd_in;
      mid_state.service = svc_in;
      mid_state.mask    = msk_in;
      mid_state.lines   = lines_in;
      mid_state.hblank  = hflag_in;
      mid_state.vblank  = vflag_in;
   end

   mfp_eval u_eval (
      .st (mid_state),
      .ev (ev)
   );

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         hblank_vec_ff <= mfp_pkg::HBLANK_VECTOR_RST;
         vblank_vec_ff <= mfp_pkg::VBLANK_VECTOR_RST;
      end else if (csr_write_enable) begin
         case (csr_index)
            mfp_pkg::CSR_HBLANK_VECTOR: hblank_vec_ff <= csr_write_data;
            mfp_pkg::CSR_VBLANK_VECTOR: vblank_vec_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_valid && !req_stall) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_op_ff    <= req_operation;
         in_idx_ff   <= req_reg_index;
         in_data_ff  <= req_write_data;
         in_lvl_ff   <= req_ack_level;
         in_lines_ff <= req_line_levels;
      end
   end

   // controller state
   always_ff @(posedge clock) begin
      if (reset) begin
         en_ff      <= 16'd0;
         pnd_ff     <= 16'd0;
         svc_ff     <= 16'd0;
         msk_ff     <= 16'd0;
         vec_reg_ff <= 8'd0;
         lines_ff   <= mfp_pkg::LINES_RST;
         hflag_ff   <= 1'b0;
         vflag_ff   <= 1'b0;
         level_ff   <= mfp_pkg::LEVEL_NONE;
         winner_ff  <= 4'd0;
      end else if (advance) begin
         en_ff      <= en_in;
         pnd_ff     <= ev.pending;
         svc_ff     <= svc_in;
         msk_ff     <= msk_in;
         vec_reg_ff <= vec_reg_in;
         lines_ff   <= lines_in;
         hflag_ff   <= hflag_in;
         vflag_ff   <= vflag_in;
         level_ff   <= ev.level;
         winner_ff  <= ev.winner;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rd_ff      <= rd_in;
         vec_out_ff <= vec_out_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_read_data = rd_ff;
   assign rsp_vector    = vec_out_ff;
   assign rsp_int_level = level_ff;

   // checks
   `MFP_ASSERT_SAME(a_b_pending_enabled, clock, reset, 1'b1,
      (pnd_ff[7:0] & ~en_ff[7:0]) == 8'd0, "b pending bit set while not enabled")
   `MFP_ASSERT_SAME(a_winner_level, clock, reset, 1'b1,
      (winner_ff != 4'd0) == (level_ff == mfp_pkg::LEVEL_MFP),
      "winning channel and level 6 disagree")
   `MFP_ASSERT_NEXT(a_hblank_raises, clock, reset,
      advance && in_op_ff == mfp_pkg::OP_HBLANK, level_ff != mfp_pkg::LEVEL_NONE,
      "hblank event left level at zero")
   `MFP_ASSERT_SAME(a_stall_needs_item, clock, reset, req_stall,
      in_valid_ff && rsp_valid_ff && rsp_stall, "input stalled without a held transaction")

endmodule
